@@ sv/pgwalk_pkg.sv @@
package pgwalk_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    // Request function codes
    localparam logic FUNC_MAP       = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_TABLE_BASE = 2'd0;
    localparam logic [1:0] REG_ROOT       = 2'd1;
    localparam logic [1:0] REG_FIRST_FREE = 2'd2;

    // Entry flags written with every entry (present, writable)
    localparam logic [1:0] ENTRY_FLAGS = 2'd3;

endpackage

@@ sv/pgwalk_ram.sv @@
module pgwalk_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write at addr, register the read of addr
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/four_level_page_table_map_walk.sv @@
// Four-level page table store with run mapping and single-page translation.
// Input channel (in_valid/in_ready) carries one request: func selects map
// (install run_length consecutive pages from virtual_page to physical_page)
// or translate (walk the four levels for virtual_page). Output channel
// (out_valid/out_ready) returns one result per request: frame_out, status
// and tables_in_use. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data), to be used only while the block is idle; the block does not enforce it.
// All table entries live in one single-port RAM with a registered read, so
// the walk is serial. A translate passes through a start state, then a
// read and an evaluate state per level, and the done state loads its
// result. Map spends per page a start state, a read and an evaluate state
// per level read, an allocate state per table allocated and a leaf write;
// its result is loaded in the done state after the last page. A zero-length
// map goes straight to the done state. in_ready rises in the cycle after
// the result is loaded. After reset the block clears the whole store,
// TABLE_PAGES*512 entries (32768 at the defaults), with in_ready low;
// configuration writes are taken meanwhile. A request is taken while an
// earlier result still waits in the output register; if the receiver
// stalls, the next result is held until the output register is free.
module four_level_page_table_map_walk #(
    parameter int TABLE_PAGES = 64,
    parameter int FRAME_BITS  = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [35:0] virtual_page,
    input  logic [39:0] physical_page,
    input  logic [20:0] run_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [39:0] frame_out,
    output logic [1:0]  status,
    output logic [6:0]  tables_in_use
);

    import pgwalk_pkg::*;

    localparam int TW    = $clog2(TABLE_PAGES);
    localparam int AW    = TW + 9;
    localparam int DEPTH = TABLE_PAGES * 512;
    localparam int NW    = ($clog2(TABLE_PAGES + 1) > 7) ? $clog2(TABLE_PAGES + 1) : 7;
    localparam int CW    = 13;
    localparam int EW    = FRAME_BITS + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_START, S_RD, S_EV, S_ALLOC, S_LEAF, S_DONE
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_reg;
    logic [39:0]           base_reg;
    logic [5:0]            root_reg;
    logic [NW-1:0]         nf_reg;
    logic                  func_reg;
    logic [35:0]           vp_reg;
    logic [FRAME_BITS-1:0] pp_reg;
    logic [20:0]           cnt_reg;
    logic [TW-1:0]         tbl_reg;
    logic [1:0]            lvl_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [1:0]            st_reg;
    logic                  out_valid_reg;
    logic [39:0]           frame_out_reg;
    logic [1:0]            status_reg;
    logic [6:0]            tiu_reg;

    logic [AW-1:0]         ram_addr;
    logic                  ram_we;
    logic [EW-1:0]         ram_wdata;
    logic [EW-1:0]         ram_rdata;
    logic [8:0]            ix;
    logic [FRAME_BITS-1:0] base_f;
    logic [FRAME_BITS-1:0] tbl_ofs;
    logic [FRAME_BITS-1:0] new_frame;
    logic [NW:0]           need_sum;
    logic                  root_out;

    pgwalk_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Pick the index of the current level
    always_comb
    begin
        case (lvl_reg)
            2'd0:    ix = vp_reg[35:27];
            2'd1:    ix = vp_reg[26:18];
            2'd2:    ix = vp_reg[17:9];
            default: ix = vp_reg[8:0];
        endcase
    end

    assign base_f    = base_reg[FRAME_BITS-1:0];
    assign tbl_ofs   = ram_rdata[FRAME_BITS-1:0] - base_f;
    assign new_frame = base_f + FRAME_BITS'(nf_reg);
    assign need_sum  = {1'b0, nf_reg} + (NW+1)'(2'd3 - lvl_reg);
    assign root_out  = {{(CW-6){1'b0}}, root_reg} >= CW'(TABLE_PAGES);

    // Drive the RAM port: clear sweep, table writes, walk reads
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_addr  = {tbl_reg, ix};
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            S_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, new_frame};
            end
            S_LEAF:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, pp_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign frame_out     = frame_out_reg;
    assign status        = status_reg;
    assign tables_in_use = tiu_reg;

    // Sequencer: walk, allocate, write and hand off results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            base_reg      <= '0;
            root_reg      <= '0;
            nf_reg        <= NW'(1);
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one is loaded now
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            // Take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TABLE_BASE: base_reg <= cfg_data;
                    REG_ROOT:       root_reg <= cfg_data[5:0];
                    REG_FIRST_FREE: nf_reg   <= NW'(cfg_data[6:0]);
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func;
                        vp_reg    <= virtual_page;
                        pp_reg    <= physical_page[FRAME_BITS-1:0];
                        cnt_reg   <= run_length;
                        frame_reg <= '0;
                        st_reg    <= ST_OK;
                        if (func == FUNC_MAP && run_length == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    tbl_reg <= TW'(root_reg);
                    lvl_reg <= 2'd0;
                    if (root_out)
                    begin
                        st_reg    <= ST_OUTSIDE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    if (!ram_rdata[FRAME_BITS])
                    begin
                        // Empty entry: fault on translate; on map, allocate or report full
                        if (func_reg == FUNC_TRANSLATE)
                        begin
                            st_reg    <= ST_UNMAPPED;
                            state_reg <= S_DONE;
                        end
                        else if (need_sum > (NW+1)'(TABLE_PAGES))
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ALLOC;
                        end
                    end
                    else if (lvl_reg == 2'd3)
                    begin
                        frame_reg <= ram_rdata[FRAME_BITS-1:0];
                        state_reg <= S_DONE;
                    end
                    else if (tbl_ofs >= FRAME_BITS'(TABLE_PAGES))
                    begin
                        st_reg    <= ST_OUTSIDE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        tbl_reg <= tbl_ofs[TW-1:0];
                        lvl_reg <= lvl_reg + 2'd1;
                        if (func_reg == FUNC_MAP && lvl_reg == 2'd2)
                        begin
                            state_reg <= S_LEAF;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_ALLOC:
                begin
                    tbl_reg <= nf_reg[TW-1:0];
                    nf_reg  <= nf_reg + NW'(1);
                    lvl_reg <= lvl_reg + 2'd1;
                    if (lvl_reg == 2'd2)
                    begin
                        state_reg <= S_LEAF;
                    end
                end
                S_LEAF:
                begin
                    // Advance to the next page of the run
                    cnt_reg <= cnt_reg - 21'd1;
                    vp_reg  <= vp_reg + 36'd1;
                    pp_reg  <= pp_reg + FRAME_BITS'(1);
                    if (cnt_reg == 21'd1)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_START;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        frame_out_reg <= 40'(frame_reg);
                        status_reg    <= st_reg;
                        tiu_reg       <= nf_reg[6:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ verif/pgwalk_checker.sv @@
module pgwalk_checker #(
    parameter int TABLE_PAGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [35:0] virtual_page,
    input  logic [39:0] physical_page,
    input  logic [20:0] run_length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [39:0] frame_out,
    input  logic [1:0]  status,
    input  logic [6:0]  tables_in_use,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import pgwalk_pkg::*;

    typedef struct packed {
        logic [39:0] frame;
        logic [1:0]  st;
        logic [6:0]  used;
    } walk_result_t;

    // Mirror of the table store and registers; absent entries read as zero
    logic [63:0]  pt_mem [int];
    logic [39:0]  base_page;
    logic [5:0]   root_tbl;
    logic [6:0]   next_free;
    walk_result_t expected_q [$];

    function automatic logic [63:0] entry_at(int t, int ix);
        return pt_mem.exists(t * 512 + ix) ? pt_mem[t * 512 + ix] : 64'd0;
    endfunction

    function automatic logic [63:0] make_entry(logic [39:0] f);
        return {12'd0, f, 10'd0, ENTRY_FLAGS};
    endfunction

    // Turn an entry into a store index; 0 if its frame lies outside the store
    function automatic bit table_of(logic [63:0] e, output int t);
        logic [39:0] d;
        d = e[51:12] - base_page;
        t = 0;
        if (d >= TABLE_PAGES)
            return 0;
        t = int'(d);
        return 1;
    endfunction

    function automatic void split_index(logic [35:0] v, output int ix [4]);
        ix[0] = int'(v[35:27]);
        ix[1] = int'(v[26:18]);
        ix[2] = int'(v[17:9]);
        ix[3] = int'(v[8:0]);
    endfunction

    // Install one page, allocating missing tables below the root
    function automatic logic [1:0] map_page(logic [35:0] v, logic [39:0] p);
        int ix [4];
        int t;
        int lvl;
        int nt;
        logic [63:0] e;
        split_index(v, ix);
        t = int'(root_tbl);
        if (t >= TABLE_PAGES)
            return ST_OUTSIDE;
        lvl = 0;
        while (lvl < 3)
        begin
            e = entry_at(t, ix[lvl]);
            if (e == 64'd0)
            begin
                if (int'(next_free) + (3 - lvl) > TABLE_PAGES)
                    return ST_FULL;
                for (; lvl < 3; lvl++)
                begin
                    nt = int'(next_free);
                    next_free = next_free + 7'd1;
                    pt_mem[t * 512 + ix[lvl]] = make_entry(base_page + 40'(nt));
                    t = nt;
                end
            end
            else
            begin
                if (!table_of(e, t))
                    return ST_OUTSIDE;
                lvl++;
            end
        end
        pt_mem[t * 512 + ix[3]] = make_entry(p);
        return ST_OK;
    endfunction

    // Walk all four levels for one page
    function automatic logic [1:0] translate_page(logic [35:0] v,
                                                  output logic [39:0] f);
        int ix [4];
        int t;
        logic [63:0] e;
        split_index(v, ix);
        f = '0;
        t = int'(root_tbl);
        if (t >= TABLE_PAGES)
            return ST_OUTSIDE;
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            e = entry_at(t, ix[lvl]);
            if (e == 64'd0)
                return ST_UNMAPPED;
            if (!table_of(e, t))
                return ST_OUTSIDE;
        end
        e = entry_at(t, ix[3]);
        if (e == 64'd0)
            return ST_UNMAPPED;
        f = e[51:12];
        return ST_OK;
    endfunction

    function automatic walk_result_t predict_request(logic fn, logic [35:0] v,
                                                     logic [39:0] p,
                                                     logic [20:0] cnt);
        walk_result_t r;
        logic [39:0] f;
        r.frame = '0;
        r.st = ST_OK;
        if (fn == FUNC_MAP)
        begin
            for (int i = 0; i < int'(cnt); i++)
            begin
                r.st = map_page(v + 36'(i), p + 40'(i));
                if (r.st != ST_OK)
                    break;
            end
        end
        else
        begin
            r.st = translate_page(v, f);
            r.frame = f;
        end
        r.used = next_free;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [39:0] got, logic [39:0] want);
        errors++;
        $display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, field, got, want);
    endtask

    // Track registers, predict accepted requests, compare results
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        if (!rst_n)
        begin
            pt_mem.delete();
            base_page = '0;
            root_tbl = '0;
            next_free = 7'd1;
            expected_q.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TABLE_BASE: base_page = cfg_data;
                    REG_ROOT:       root_tbl = cfg_data[5:0];
                    REG_FIRST_FREE: next_free = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_request(func, virtual_page,
                                                     physical_page, run_length));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with no request outstanding", $time);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (frame_out !== want.frame)
                        report_mismatch("frame_out", frame_out, want.frame);
                    if (status !== want.st)
                        report_mismatch("status", 40'(status), 40'(want.st));
                    if (tables_in_use !== want.used)
                        report_mismatch("tables_in_use", 40'(tables_in_use),
                                        40'(want.used));
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pgwalk_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000000;
    localparam int RANDOM_ITEMS   = 950;
    localparam int NUM_PHASES     = 9;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [39:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [35:0] virtual_page;
    logic [39:0] physical_page;
    logic [20:0] run_length;
    logic        out_valid;
    logic        out_ready;
    logic [39:0] frame_out;
    logic [1:0]  status;
    logic [6:0]  tables_in_use;
    int          pending;
    int          errors;

    bit          hold_output;
    int          idle_cycles;
    int          map_reqs;
    int          xlate_reqs;
    int          settings_used;
    logic [35:0] region [4];
    logic [35:0] mapped_pages [$];

    four_level_page_table_map_walk dut (.*);

    pgwalk_checker checker_i (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("four_level_page_table_map_walk verification failed");
            $finish;
        end
    end

    // Receiver: random ready pattern, plus one long hold on request
    initial
    begin
        int r;
        out_ready = 1'b0;
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_output = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else if (r < 92)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge clk);
                end
            end
        end
    end

    // Write all three registers back to back
    task automatic set_config(logic [39:0] base, logic [5:0] root, logic [6:0] first);
        cfg_we <= 1'b1;
        cfg_index <= REG_TABLE_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= REG_ROOT;
        cfg_data <= 40'(root);
        @(posedge clk);
        cfg_index <= REG_FIRST_FREE;
        cfg_data <= 40'(first);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Offer one request and hold it until taken; valid stays high afterward
    task automatic send(logic fn, logic [35:0] v, logic [39:0] p, logic [20:0] cnt);
        in_valid <= 1'b1;
        func <= fn;
        virtual_page <= v;
        physical_page <= p;
        run_length <= cnt;
        if (fn == FUNC_MAP)
            map_reqs++;
        else
            xlate_reqs++;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return;
        in_valid <= 1'b0;
        if (r < 90)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 40)) @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    // Random requests clustered around a few regions so walks go deep
    task automatic random_phase(int n, bit near_full);
        logic        fn;
        logic [35:0] v;
        logic [20:0] cnt;
        int          r;
        for (int k = 0; k < 4; k++)
            region[k] = 36'({$urandom, $urandom}) & 36'hF_FFFF_FE00;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && settings_used == 5)
                hold_output = 1'b1;
            fn = ($urandom_range(0, 99) < 45) ? FUNC_MAP : FUNC_TRANSLATE;
            r = $urandom_range(0, 99);
            if (fn == FUNC_TRANSLATE && mapped_pages.size() > 0 && r < 60)
                v = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)]
                    + 36'($urandom_range(0, 2));
            else if (r < 85)
                v = region[$urandom_range(0, 3)] + 36'($urandom_range(0, 700));
            else
                v = 36'({$urandom, $urandom});
            r = $urandom_range(0, 99);
            if (fn == FUNC_TRANSLATE || near_full)
                cnt = 21'($urandom_range(0, 1048576));
            else if (r < 70)
                cnt = 21'($urandom_range(1, 4));
            else if (r < 90)
                cnt = 21'($urandom_range(5, 40));
            else if (r < 95)
                cnt = '0;
            else
                cnt = 21'($urandom_range(64, 300));
            if (fn == FUNC_MAP)
            begin
                mapped_pages.push_back(v);
                if (mapped_pages.size() > 64)
                    void'(mapped_pages.pop_front());
            end
            send(fn, v, 40'({$urandom, $urandom}), cnt);
            sender_gap();
        end
    endtask

    initial
    begin
        logic [6:0] first;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TABLE_BASE;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_MAP;
        virtual_page = '0;
        physical_page = '0;
        run_length = '0;
        hold_output = 1'b0;
        idle_cycles = 0;
        map_reqs = 0;
        xlate_reqs = 0;
        settings_used = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, zero count, overwrite, wraps, PT boundary
        set_config(40'd0, 6'd0, 7'd1);
        send(FUNC_TRANSLATE, 36'd0, 40'd0, 21'd0);
        send(FUNC_MAP, 36'd0, 40'd0, 21'd0);
        send(FUNC_MAP, 36'd0, 40'hFF_FFFF_FFFF, 21'd1);
        send(FUNC_TRANSLATE, 36'd0, 40'd0, 21'd0);
        send(FUNC_MAP, 36'd0, 40'd5, 21'd1);
        send(FUNC_TRANSLATE, 36'd0, 40'd0, 21'h1F_FFFF);
        send(FUNC_MAP, 36'hF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 21'd3);
        send(FUNC_TRANSLATE, 36'hF_FFFF_FFFF, 40'd0, 21'd0);
        send(FUNC_TRANSLATE, 36'd1, 40'd0, 21'd0);
        send(FUNC_MAP, 36'h1FE, 40'h12_3456_789A, 21'd4);
        send(FUNC_TRANSLATE, 36'h200, 40'd0, 21'd0);
        send(FUNC_TRANSLATE, 36'h5_5555_5555, 40'd0, 21'd0);
        drain();

        // Directed: no tables left, huge runs stop at the first fault
        set_config(40'd0, 6'd0, 7'd64);
        send(FUNC_MAP, 36'h1_2345_6789, 40'd7, 21'h10_0000);
        send(FUNC_TRANSLATE, 36'h1_2345_6789, 40'd0, 21'd0);
        send(FUNC_MAP, 36'd1, 40'h55_AAAA_5555, 21'h10_0000);
        send(FUNC_TRANSLATE, 36'h3FF, 40'd0, 21'd0);
        drain();

        // Directed: moved table base leaves old pointers outside the store
        set_config(40'd5, 6'd0, 7'd1);
        send(FUNC_TRANSLATE, 36'd0, 40'd0, 21'd0);
        send(FUNC_MAP, 36'd0, 40'd9, 21'd2);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(40'd0, 6'd0, 7'd0);
                1: set_config(40'hFF_FFFF_FFFF, 6'd63, 7'd1);
                2: set_config(40'hFF_FFFF_FFFF, 6'd63, 7'd20);
                NUM_PHASES - 1: set_config(40'd0, 6'd0, 7'd64);
                default:
                begin
                    first = 7'($urandom_range(0, 64));
                    set_config(40'({$urandom, $urandom}), 6'($urandom_range(0, 63)), first);
                end
            endcase
            random_phase(RANDOM_ITEMS / NUM_PHASES, checker_i.next_free >= 7'd61);
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Summary: %0d map and %0d translate requests over %0d register settings",
                 map_reqs, xlate_reqs, settings_used);
        if (errors == 0)
            $display("four_level_page_table_map_walk verification clean");
        else
            $display("four_level_page_table_map_walk verification failed");
        $finish;
    end

endmodule
